/* rtl/core/srd_pkg.sv */
// Package for the SLIP response deframer.
// Holds word types, function codes, register indexes and framing constants.
// No dependencies.
package srd_pkg;

	localparam int unsigned RESPONSE_BYTES = 1024;
	localparam int unsigned MAX_INDEX = 1023;
	localparam int unsigned TICK_W = 13;
	localparam int unsigned IDX_W = 10;

	localparam logic [7:0] SLIP_END = 8'hC0;
	localparam logic [7:0] SLIP_ESC = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	localparam logic [TICK_W-1:0] WAIT_TIMEOUT_RESET = 13'd5000;
	localparam logic [TICK_W-1:0] BYTE_TIMEOUT_RESET = 13'd100;

	typedef enum logic [1:0] {
		FUNC_BYTE = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_ARM  = 2'd2,
		FUNC_LINK_LOST = 2'd3
	} func_t;

	typedef enum logic {
		REG_WAIT_TIMEOUT = 1'b0,
		REG_BYTE_TIMEOUT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
		logic [7:0] expected_seq;
		logic       status_request;
	} srd_in_t;

	typedef struct packed {
		logic             store;
		logic [IDX_W-1:0] write_index;
		logic [7:0]       write_byte;
		logic             done_res;
		logic             bus_error;
		logic [IDX_W-1:0] status_count;
		logic             status_count_valid;
		logic             overflow;
	} srd_out_t;

	typedef struct packed {
		logic [TICK_W-1:0] wait_timeout_ticks;
		logic [TICK_W-1:0] byte_timeout_ticks;
	} srd_cfg_t;

endpackage

/* rtl/core/slip_response_deframer.sv */
// Top level of the SLIP response deframer: input stage, config registers,
// result register. Depends on srd_pkg and srd_core.
//
// Takes one word per clock while item_ready is high (byte, tick, arm or link
// lost) and returns at most one result word for it. The word is decoded out of
// the input register, and its result is loaded into the result register when
// the result register is empty or result_ready is high. Throughput is one word
// per cycle while result_ready is high. While a result waits for result_ready,
// the input register still takes one more word, and then item_ready drops.
// Timeout registers reset to 5000 and 100 ticks; the user must write them only
// while no word is in flight, and the block itself does not enforce this.
module slip_response_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  srd_pkg::srd_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output srd_pkg::srd_out_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [12:0]       cfg_data
);
	import srd_pkg::*;

	srd_in_t  item_s1;
	logic     valid_s1;
	srd_cfg_t cfg_q;
	logic     result_valid_q;
	srd_out_t result_q;
	logic     adv;
	logic     fire;
	logic     res_valid;
	srd_out_t res;

	assign adv = !result_valid_q || result_ready;
	assign fire = valid_s1 && adv;
	assign item_ready = !valid_s1 || adv;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_timeout_ticks <= WAIT_TIMEOUT_RESET;
			cfg_q.byte_timeout_ticks <= BYTE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_WAIT_TIMEOUT: cfg_q.wait_timeout_ticks <= cfg_data;
				REG_BYTE_TIMEOUT: cfg_q.byte_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid)
			result_q <= res;
	end

	srd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

/* rtl/core/srd_core.sv */
// Deframer state and per-word decode: SLIP unescape, sequence match, timeouts.
// Depends on srd_pkg.
module srd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  srd_pkg::srd_in_t  item,
	input  srd_pkg::srd_cfg_t cfg,
	output logic           res_valid,
	output srd_pkg::srd_out_t res
);
	import srd_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_ACTIVE = 2'd1,
		MODE_ESCAPE = 2'd2
	} mode_t;

	mode_t             mode_q, mode_n;
	logic              awaiting_q, awaiting_n;
	logic              armed_q, armed_n;
	logic [TICK_W-1:0] elapsed_q, elapsed_n;
	logic [IDX_W-1:0]  byte_count_q, byte_count_n;
	logic              gap_q, gap_n;
	logic [7:0]        seq_q, seq_n;
	logic              status_q, status_n;

	logic              dlv;
	logic [7:0]        dbyte;
	logic [TICK_W-1:0] limit;
	logic [IDX_W:0]    idx;

	always_comb begin
		mode_n = mode_q;
		awaiting_n = awaiting_q;
		armed_n = armed_q;
		elapsed_n = elapsed_q;
		byte_count_n = byte_count_q;
		gap_n = gap_q;
		seq_n = seq_q;
		status_n = status_q;
		res = '0;
		res_valid = 1'b0;
		dlv = 1'b0;
		dbyte = item.rx_byte;
		idx = '0;
		limit = awaiting_q ? cfg.wait_timeout_ticks : cfg.byte_timeout_ticks;

		unique case (func_t'(item.func))
			FUNC_ARM: begin
				seq_n = item.expected_seq;
				status_n = item.status_request;
				armed_n = 1'b1;
				awaiting_n = 1'b1;
				mode_n = MODE_IDLE;
				elapsed_n = '0;
				byte_count_n = '0;
				gap_n = 1'b0;
			end
			FUNC_LINK_LOST: begin
				if (armed_q) begin
					res_valid = 1'b1;
					res.bus_error = 1'b1;
				end
			end
			FUNC_TICK: begin
				if (armed_q) begin
					if (elapsed_q >= limit) begin
						res_valid = 1'b1;
						res.bus_error = 1'b1;
					end else begin
						elapsed_n = elapsed_q + 1'b1;
					end
				end
			end
			FUNC_BYTE: begin
				if (armed_q) begin
					unique case (mode_q)
						MODE_ACTIVE: begin
							if (item.rx_byte == SLIP_END) begin
								res_valid = 1'b1;
								res.done_res = 1'b1;
								if (gap_q) begin
									res.status_count = byte_count_q - 1'b1;
									res.status_count_valid = 1'b1;
								end
							end else if (item.rx_byte == SLIP_ESC) begin
								mode_n = MODE_ESCAPE;
							end else begin
								dlv = 1'b1;
							end
						end
						MODE_ESCAPE: begin
							if (item.rx_byte == SLIP_ESC_END) begin
								mode_n = MODE_ACTIVE;
								dlv = 1'b1;
								dbyte = SLIP_END;
							end else if (item.rx_byte == SLIP_ESC_ESC) begin
								mode_n = MODE_ACTIVE;
								dlv = 1'b1;
								dbyte = SLIP_ESC;
							end else begin
								res_valid = 1'b1;
								res.bus_error = 1'b1;
							end
						end
						default: begin
							mode_n = (item.rx_byte == SLIP_END) ? MODE_ACTIVE : MODE_IDLE;
						end
					endcase
				end
			end
			default: ;
		endcase

		// closing END, bad escape, timeout and link loss all disarm
		if (res_valid) begin
			armed_n = 1'b0;
			mode_n = MODE_IDLE;
			awaiting_n = 1'b1;
			elapsed_n = '0;
		end

		if (dlv) begin
			elapsed_n = '0;
			if (awaiting_q) begin
				if (dbyte == seq_q)
					awaiting_n = 1'b0;
				else
					mode_n = MODE_IDLE;
			end else begin
				gap_n = gap_q | (status_q && byte_count_q == IDX_W'(1));
				idx = {1'b0, byte_count_q} + (gap_n ? (IDX_W+1)'(2) : '0);
				res_valid = 1'b1;
				if (int'(idx) < RESPONSE_BYTES && idx <= (IDX_W+1)'(MAX_INDEX)) begin
					res.store = 1'b1;
					res.write_index = idx[IDX_W-1:0];
					res.write_byte = dbyte;
				end else begin
					res.overflow = 1'b1;
				end
				if (byte_count_q < IDX_W'(MAX_INDEX))
					byte_count_n = byte_count_q + 1'b1;
			end
		end

		if (!fire) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			awaiting_q <= 1'b1;
			armed_q <= 1'b0;
			elapsed_q <= '0;
			byte_count_q <= '0;
			gap_q <= 1'b0;
			seq_q <= '0;
			status_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_n;
			awaiting_q <= awaiting_n;
			armed_q <= armed_n;
			elapsed_q <= elapsed_n;
			byte_count_q <= byte_count_n;
			gap_q <= gap_n;
			seq_q <= seq_n;
			status_q <= status_n;
		end
	end

`ifndef SYNTH
	a_end_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && (res.done_res || res.bus_error) |=> !armed_q)
		else $error("frame end left the deframer armed");

	a_arm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.func == FUNC_ARM |=> armed_q && awaiting_q && byte_count_q == '0)
		else $error("arm did not restart the response");

	a_count_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status_count_valid |-> res.done_res)
		else $error("status count outside a done word");

	a_no_store_while_awaiting: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.store |-> !awaiting_q && armed_q)
		else $error("store before the sequence byte matched");
`endif

endmodule
